### rtl/pdkf_pkg.sv
package pdkf_pkg;

    localparam int unsigned MAX_FRAME_PIXELS = 1048576;
    localparam int unsigned TALLY_W          = 21;
    localparam int unsigned TALLY_FIELD_MAX  = (1 << TALLY_W) - 1;
    localparam logic [TALLY_W-1:0] TALLY_CAP =
        TALLY_W'((MAX_FRAME_PIXELS < TALLY_FIELD_MAX) ? MAX_FRAME_PIXELS : TALLY_FIELD_MAX);

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [31:0] TEN_Q16 = 32'd655360;
    // Reciprocal of three for an exact divide of a 32-bit value: (v * RECIP3) >> 33.
    localparam logic [31:0] RECIP3  = 32'hAAAAAAAB;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        REG_MIN_VAR    = 3'd0,
        REG_MAX_VAR    = 3'd1,
        REG_FORGET     = 3'd2,
        REG_GAIN_FLOOR = 3'd3,
        REG_GATE_THR   = 3'd4,
        REG_SCALE_NOISE = 3'd5,
        REG_DEPTH_LIMIT = 3'd6,
        REG_COUNT_EN   = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_OBS   = 2'd1,
        KIND_PRIOR = 2'd2,
        KIND_BOTH  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [31:0] min_var;
        logic [31:0] max_var;
        logic [15:0] forget;
        logic [16:0] gain_floor;
        logic [31:0] gate_thr;
        logic [31:0] scale_noise;
        logic [31:0] depth_limit;
        logic        count_en;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] zp;
        logic [31:0] zo;
        logic [31:0] id;
        logic [31:0] diff;
        logic        zo_ge;
        logic [31:0] vpe;
        logic [31:0] voe;
        logic [32:0] vin;
        logic [31:0] base;
        logic [31:0] ovar;
        logic        last;
    } t_job;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SIMPLE,
        ST_PRIOR,
        ST_PRIOR_FIN,
        ST_INNOV,
        ST_SQ0,
        ST_SQ1,
        ST_SQ2,
        ST_SQ3,
        ST_GATE,
        ST_CDEN,
        ST_CX_CHK,
        ST_CX_DIV,
        ST_XX,
        ST_X2,
        ST_X4,
        ST_X6,
        ST_POLY,
        ST_CDIV,
        ST_CAP,
        ST_KSTART,
        ST_KDIV,
        ST_POST0,
        ST_POST1,
        ST_POST2,
        ST_POST3,
        ST_POST4,
        ST_POST5,
        ST_EMIT
    } t_state;

endpackage

### rtl/pdkf_front.sv
module pdkf_front import pdkf_pkg::*; (
    input  t_cfg        i_cfg,
    input  logic [31:0] i_prior_depth,
    input  logic [31:0] i_observed_depth,
    input  logic [31:0] i_prior_variance,
    input  logic [31:0] i_observed_variance,
    input  logic [31:0] i_relative_inverse_depth,
    input  logic        i_frame_last,
    output t_job        o_job
);

    logic        sp;
    logic        so;
    logic [31:0] base;
    logic [31:0] vpe;
    logic [31:0] voe;

    always_comb begin
        sp   = (i_relative_inverse_depth != '0) && (i_prior_depth != '0);
        so   = (i_relative_inverse_depth != '0) && (i_observed_depth != '0);
        base = (i_prior_variance != '0) ? i_prior_variance : TEN_Q16;
        vpe  = (base < i_cfg.min_var) ? i_cfg.min_var : base;
        voe  = (i_observed_variance < i_cfg.min_var) ? i_cfg.min_var : i_observed_variance;

        if (!sp && !so) begin
            o_job.kind = KIND_NONE;
        end else if (!sp) begin
            o_job.kind = KIND_OBS;
        end else if (!so) begin
            o_job.kind = KIND_PRIOR;
        end else begin
            o_job.kind = KIND_BOTH;
        end

        o_job.zp    = i_prior_depth;
        o_job.zo    = i_observed_depth;
        o_job.id    = i_relative_inverse_depth;
        o_job.zo_ge = (i_observed_depth >= i_prior_depth);
        o_job.diff  = o_job.zo_ge ? (i_observed_depth - i_prior_depth)
                                  : (i_prior_depth - i_observed_depth);
        o_job.vpe   = vpe;
        o_job.voe   = voe;
        o_job.vin   = {1'b0, vpe} + {1'b0, voe};
        o_job.base  = base;
        o_job.ovar  = (i_observed_variance != '0) ? i_observed_variance : i_cfg.max_var;
        o_job.last  = i_frame_last;
    end

endmodule

### rtl/pdkf_queue.sv
module pdkf_queue import pdkf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

### rtl/pdkf_div.sv
module pdkf_div import pdkf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    input  logic [4:0]  i_nbits,
    output logic        o_busy,
    output logic [19:0] o_quo
);

    // Restoring division, one quotient bit per cycle. The caller guarantees
    // that the quotient fits in i_nbits bits.
    logic [63:0] r_rem;
    logic [82:0] r_dsh;
    logic [19:0] r_quo;
    logic [4:0]  r_cnt;
    logic        ge;

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;
    assign ge     = ({19'b0, r_rem} >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_nbits;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= {19'b0, i_den} << (i_nbits - 5'd1);
            r_quo <= '0;
        end else if (o_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh[63:0];
            end
            r_quo <= {r_quo[18:0], ge};
            r_dsh <= r_dsh >> 1;
        end
    end

endmodule

### rtl/pdkf_back.sv
module pdkf_back import pdkf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_job        i_job,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_fused_depth,
    output logic        o_fused_depth_ok,
    output logic [31:0] o_fused_variance,
    output logic        o_frame_done,
    output logic [20:0] o_gated_count,
    output logic [20:0] o_rejected_count
);

    t_state r_state;
    t_state n_state;
    t_job   r_job;

    logic [65:0]  r_prod;
    logic [127:0] r_acc;
    logic [63:0]  r_innov;
    logic [19:0]  r_x;
    logic [20:0]  r_x2;
    logic [25:0]  r_x4;
    logic [16:0]  r_cons;
    logic [16:0]  r_cap;
    logic [16:0]  r_k;

    logic [31:0] r_res_depth;
    logic        r_res_ok;
    logic [31:0] r_res_var;

    logic [TALLY_W-1:0] r_gated;
    logic [TALLY_W-1:0] r_rejected;

    logic        r_ovalid;
    logic [31:0] r_odepth;
    logic        r_ook;
    logic [31:0] r_ovar;
    logic        r_odone;
    logic [20:0] r_ogated;
    logic [20:0] r_orej;

    logic [32:0] n_ma;
    logic [32:0] n_mb;
    logic        div_start;
    logic [63:0] div_num;
    logic [63:0] div_den;
    logic [4:0]  div_nbits;
    logic        div_busy;
    logic [19:0] div_quo;

    logic        emit;
    logic        reject;
    logic        cons_zero;
    logic        xx_big;
    logic [16:0] fg_sat;
    logic [16:0] omk;
    logic [27:0] poly;
    logic [65:0] post_sum;
    logic [33:0] post_min;
    logic [32:0] pri_v;
    logic [32:0] pri_min;
    logic [32:0] delta;
    logic [32:0] depth_raw;

    pdkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_nbits (div_nbits),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    always_comb begin
        fg_sat    = (i_cfg.gain_floor > ONE_Q16) ? ONE_Q16 : i_cfg.gain_floor;
        omk       = ONE_Q16 - r_k;
        reject    = (r_acc > {31'b0, r_prod[64:0], 32'b0});
        cons_zero = (i_cfg.scale_noise == '0) ||
                    ({20'b0, r_job.diff, 32'b0} >= {r_prod[63:0], 20'b0});
        xx_big    = (r_prod >= (66'd18 << 32));
        poly      = 28'(ONE_Q16) + 28'(r_x2 >> 1) + 28'(r_x4 >> 3) + 28'(r_prod[57:33]);
        post_sum  = r_acc[65:0] + r_prod;
        post_min  = (post_sum[65:32] < 34'(i_cfg.min_var)) ? 34'(i_cfg.min_var)
                                                            : post_sum[65:32];
        pri_v     = r_prod[48:16];
        pri_min   = (pri_v < 33'(i_cfg.min_var)) ? 33'(i_cfg.min_var) : pri_v;
        delta     = r_prod[48:16];
        depth_raw = r_job.zo_ge ? (33'(r_job.zp) + delta) : (33'(r_job.zp) - delta);
        emit      = (r_state == ST_EMIT) && (!r_ovalid || i_ready);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    unique case (i_job.kind)
                        KIND_NONE, KIND_OBS: n_state = ST_SIMPLE;
                        KIND_PRIOR:          n_state = ST_PRIOR;
                        KIND_BOTH:           n_state = ST_INNOV;
                    endcase
                end
            end
            ST_SIMPLE:    n_state = ST_EMIT;
            ST_PRIOR:     n_state = ST_PRIOR_FIN;
            ST_PRIOR_FIN: n_state = ST_EMIT;
            ST_INNOV:     n_state = ST_SQ0;
            ST_SQ0:       n_state = ST_SQ1;
            ST_SQ1:       n_state = ST_SQ2;
            ST_SQ2:       n_state = ST_SQ3;
            ST_SQ3:       n_state = ST_GATE;
            ST_GATE:      n_state = reject ? ST_EMIT : ST_CDEN;
            ST_CDEN:      n_state = ST_CX_CHK;
            ST_CX_CHK:    n_state = cons_zero ? ST_CAP : ST_CX_DIV;
            ST_CX_DIV:    n_state = div_busy ? ST_CX_DIV : ST_XX;
            ST_XX:        n_state = ST_X2;
            ST_X2:        n_state = xx_big ? ST_CAP : ST_X4;
            ST_X4:        n_state = ST_X6;
            ST_X6:        n_state = ST_POLY;
            ST_POLY:      n_state = ST_CDIV;
            ST_CDIV:      n_state = div_busy ? ST_CDIV : ST_CAP;
            ST_CAP:       n_state = ST_KSTART;
            ST_KSTART:    n_state = ST_KDIV;
            ST_KDIV:      n_state = div_busy ? ST_KDIV : ST_POST0;
            ST_POST0:     n_state = ST_POST1;
            ST_POST1:     n_state = ST_POST2;
            ST_POST2:     n_state = ST_POST3;
            ST_POST3:     n_state = ST_POST4;
            ST_POST4:     n_state = ST_POST5;
            ST_POST5:     n_state = ST_EMIT;
            ST_EMIT:      n_state = emit ? ST_IDLE : ST_EMIT;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Multiplier operands and divider control.
    always_comb begin
        n_ma      = '0;
        n_mb      = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_nbits = '0;
        o_pop     = (r_state == ST_IDLE) && !i_empty;
        unique case (r_state)
            ST_PRIOR: begin
                n_ma = 33'(r_job.base);
                n_mb = 33'(ONE_Q16 + 17'(i_cfg.forget));
            end
            ST_INNOV: begin
                n_ma = 33'(r_job.diff);
                n_mb = 33'(r_job.id);
            end
            ST_SQ0: begin
                n_ma = 33'(r_prod[31:0]);
                n_mb = 33'(r_prod[31:0]);
            end
            ST_SQ1: begin
                n_ma = 33'(r_innov[31:0]);
                n_mb = 33'(r_innov[63:32]);
            end
            ST_SQ2: begin
                n_ma = 33'(r_innov[63:32]);
                n_mb = 33'(r_innov[63:32]);
            end
            ST_SQ3: begin
                n_ma = 33'(i_cfg.gate_thr);
                n_mb = r_job.vin;
            end
            ST_CDEN: begin
                n_ma = 33'(r_job.zo);
                n_mb = 33'(i_cfg.scale_noise);
            end
            ST_CX_CHK: begin
                div_start = !cons_zero;
                div_num   = {r_job.diff, 32'b0};
                div_den   = r_prod[63:0];
                div_nbits = 5'd20;
            end
            ST_XX: begin
                n_ma = 33'(r_x);
                n_mb = 33'(r_x);
            end
            ST_X2: begin
                n_ma = 33'(r_prod[36:16]);
                n_mb = 33'(r_prod[36:16]);
            end
            ST_X4: begin
                n_ma = 33'(r_prod[41:16]);
                n_mb = 33'(r_x2);
            end
            ST_X6: begin
                n_ma = 33'(r_prod[45:20]);
                n_mb = 33'(RECIP3);
            end
            ST_POLY: begin
                div_start = 1'b1;
                div_num   = 64'h1_0000_0000;
                div_den   = 64'(poly);
                div_nbits = 5'd17;
            end
            ST_CAP: begin
                n_ma = 33'(ONE_Q16 - fg_sat);
                n_mb = 33'(r_cons);
            end
            ST_KSTART: begin
                div_start = 1'b1;
                div_num   = 64'(r_job.vpe) << 16;
                div_den   = 64'(r_job.vin);
                div_nbits = 5'd17;
            end
            ST_POST0: begin
                n_ma = 33'(omk);
                n_mb = 33'(omk);
            end
            ST_POST1: begin
                n_ma = r_prod[32:0];
                n_mb = 33'(r_job.vpe);
            end
            ST_POST2: begin
                n_ma = 33'(r_k);
                n_mb = 33'(r_k);
            end
            ST_POST3: begin
                n_ma = r_prod[32:0];
                n_mb = 33'(r_job.voe);
            end
            ST_POST4: begin
                n_ma = 33'(r_k);
                n_mb = 33'(r_job.diff);
            end
            default: begin
                n_ma = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_gated    <= '0;
            r_rejected <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if ((r_state == ST_GATE) && i_cfg.count_en) begin
                if (r_gated < TALLY_CAP) begin
                    r_gated <= r_gated + 1'b1;
                end
                if (reject && (r_rejected < TALLY_CAP)) begin
                    r_rejected <= r_rejected + 1'b1;
                end
            end else if (emit && r_job.last) begin
                r_gated    <= '0;
                r_rejected <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 66'(n_ma) * 66'(n_mb);
        if (o_pop) begin
            r_job <= i_job;
        end
        unique case (r_state)
            ST_SIMPLE: begin
                if (r_job.kind == KIND_OBS) begin
                    r_res_depth <= r_job.zo;
                    r_res_ok    <= 1'b1;
                    r_res_var   <= r_job.ovar;
                end else begin
                    r_res_depth <= '0;
                    r_res_ok    <= 1'b0;
                    r_res_var   <= i_cfg.max_var;
                end
            end
            ST_PRIOR_FIN: begin
                r_res_depth <= r_job.zp;
                r_res_ok    <= 1'b1;
                r_res_var   <= (pri_min > 33'(i_cfg.max_var)) ? i_cfg.max_var : pri_min[31:0];
            end
            ST_SQ0: r_innov <= r_prod[63:0];
            ST_SQ1: r_acc <= 128'(r_prod[63:0]);
            ST_SQ2: r_acc <= r_acc + (128'(r_prod[63:0]) << 33);
            ST_SQ3: r_acc <= r_acc + (128'(r_prod[63:0]) << 64);
            ST_GATE: begin
                // A rejected pixel keeps the prior, clamped.
                r_res_ok    <= 1'b1;
                r_res_depth <= (r_job.zp > i_cfg.depth_limit) ? i_cfg.depth_limit : r_job.zp;
                r_res_var   <= (r_job.vpe > i_cfg.max_var) ? i_cfg.max_var : r_job.vpe;
            end
            ST_CX_CHK: begin
                if (cons_zero) begin
                    r_cons <= '0;
                end
            end
            ST_CX_DIV: r_x <= div_quo;
            ST_X2: begin
                if (xx_big) begin
                    r_cons <= '0;
                end
                r_x2 <= r_prod[36:16];
            end
            ST_X4:     r_x4 <= r_prod[41:16];
            ST_CDIV:   r_cons <= div_quo[16:0];
            ST_KSTART: r_cap <= fg_sat + r_prod[32:16];
            ST_KDIV:   r_k <= (div_quo[16:0] < r_cap) ? div_quo[16:0] : r_cap;
            ST_POST2:  r_acc <= 128'(r_prod);
            ST_POST4: begin
                r_res_var <= (post_min > 34'(i_cfg.max_var)) ? i_cfg.max_var : post_min[31:0];
            end
            ST_POST5: begin
                r_res_ok    <= 1'b1;
                r_res_depth <= (depth_raw > 33'(i_cfg.depth_limit)) ? i_cfg.depth_limit
                                                                     : depth_raw[31:0];
            end
            default: begin
                r_res_ok <= r_res_ok;
            end
        endcase
        if (emit) begin
            r_odepth <= r_res_depth;
            r_ook    <= r_res_ok;
            r_ovar   <= r_res_var;
            r_odone  <= r_job.last;
            r_ogated <= r_job.last ? 21'(r_gated) : '0;
            r_orej   <= r_job.last ? 21'(r_rejected) : '0;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_fused_depth    = r_odepth;
    assign o_fused_depth_ok = r_ook;
    assign o_fused_variance = r_ovar;
    assign o_frame_done     = r_odone;
    assign o_gated_count    = r_ogated;
    assign o_rejected_count = r_orej;

`ifndef NO_ASSERTIONS
    a_tally_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gated <= TALLY_CAP) && (r_rejected <= TALLY_CAP))
        else $error("tally above saturation limit");
    a_rej_le_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rejected <= r_gated)
        else $error("rejected tally exceeds gated tally");
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POST0) |-> (r_k <= ONE_Q16))
        else $error("gain above one");
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");
`endif

endmodule

### rtl/pixel_depth_kalman_fusion_top.sv
// Channel   Direction  Handshake            Payload
// pixel     in         i_valid / o_ready    prior/observed depth and variance, inverse depth, last
// result    out        o_valid / i_ready    fused depth, ok flag, variance, frame counts
// config    in         APB psel/penable     eight registers at byte address 4*index
//
// A pixel with neither source or only the observation valid goes straight to the result, a prior-only
// pixel scales the prior variance, a gate-rejected pixel stops after the gate, and a fused pixel runs all.
// The fused case runs up to three bit-serial divisions (20, 17 and 17 quotient bits) in
// the back end, which also shares one 33x33 multiplier over all its products.
// Reset is synchronous and active low; it restores the register defaults and clears the tallies.
// A two-entry queue parts the front from the back, so input is taken while a result stalls.
module pixel_depth_kalman_fusion_top import pdkf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_prior_depth,
    input  logic [31:0] i_observed_depth,
    input  logic [31:0] i_prior_variance,
    input  logic [31:0] i_observed_variance,
    input  logic [31:0] i_relative_inverse_depth,
    input  logic        i_frame_last,

    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_fused_depth,
    output logic        o_fused_depth_ok,
    output logic [31:0] o_fused_variance,
    output logic        o_frame_done,
    output logic [20:0] o_gated_count,
    output logic [20:0] o_rejected_count,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers. Software must write them only while the block is idle, which the block
    // itself does not enforce; the datapath reads them directly.
    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    t_job front_job;
    t_job head_job;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic push;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_var     <= 32'd66;
            r_cfg.max_var     <= 32'd655360;
            r_cfg.forget      <= 16'd3277;
            r_cfg.gain_floor  <= 17'd6554;
            r_cfg.gate_thr    <= 32'd589824;
            r_cfg.scale_noise <= 32'd6554;
            r_cfg.depth_limit <= 32'd6553600;
            r_cfg.count_en    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MIN_VAR:     r_cfg.min_var     <= pwdata;
                REG_MAX_VAR:     r_cfg.max_var     <= pwdata;
                REG_FORGET:      r_cfg.forget      <= pwdata[15:0];
                REG_GAIN_FLOOR:  r_cfg.gain_floor  <= pwdata[16:0];
                REG_GATE_THR:    r_cfg.gate_thr    <= pwdata;
                REG_SCALE_NOISE: r_cfg.scale_noise <= pwdata;
                REG_DEPTH_LIMIT: r_cfg.depth_limit <= pwdata;
                REG_COUNT_EN:    r_cfg.count_en    <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MIN_VAR:     prdata = r_cfg.min_var;
            REG_MAX_VAR:     prdata = r_cfg.max_var;
            REG_FORGET:      prdata = 32'(r_cfg.forget);
            REG_GAIN_FLOOR:  prdata = 32'(r_cfg.gain_floor);
            REG_GATE_THR:    prdata = r_cfg.gate_thr;
            REG_SCALE_NOISE: prdata = r_cfg.scale_noise;
            REG_DEPTH_LIMIT: prdata = r_cfg.depth_limit;
            REG_COUNT_EN:    prdata = 32'(r_cfg.count_en);
        endcase
    end

    // The front classifies each pixel and precomputes the effective variances,
    // then the transaction waits in the queue until the back end is free.
    assign o_ready = !q_full;
    assign push    = i_valid && o_ready;

    pdkf_front u_front (
        .i_cfg                    (r_cfg),
        .i_prior_depth            (i_prior_depth),
        .i_observed_depth         (i_observed_depth),
        .i_prior_variance         (i_prior_variance),
        .i_observed_variance      (i_observed_variance),
        .i_relative_inverse_depth (i_relative_inverse_depth),
        .i_frame_last             (i_frame_last),
        .o_job                    (front_job)
    );

    pdkf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // The back end runs the gate, the consistency weight and the Kalman update,
    // keeps the frame tallies and holds the result in an output register.
    pdkf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_job            (head_job),
        .i_empty          (q_empty),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_fused_depth    (o_fused_depth),
        .o_fused_depth_ok (o_fused_depth_ok),
        .o_fused_variance (o_fused_variance),
        .o_frame_done     (o_frame_done),
        .o_gated_count    (o_gated_count),
        .o_rejected_count (o_rejected_count)
    );

endmodule
